### hdl/adgd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// AdaGrad update package
// Widths, pipeline depths and the sideband record shared by the update block.
// ----------------------------------------------------------------------------
package adgd_pkg;

  localparam int IDX_W       = 12;
  localparam int DATA_W      = 32;
  localparam int ACC_W       = 64;
  localparam int ROOT_W      = 32;
  localparam int DEN_W       = 33;
  localparam int QUO_W       = 56;
  localparam int SQRT_STAGES = 16;
  localparam int DIV_STAGES  = 28;

  localparam logic [DATA_W-1:0] LR_RESET = 32'd167772;

  // Per-item data that rides along with the arithmetic.
  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] weight;
    logic                     neg;
    logic [DATA_W-1:0]        mag;
    logic                     in_range;
  } side_t;

endpackage
`default_nettype wire

### hdl/adgd_isqrt_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 64-bit word, two result bits per stage.
// ----------------------------------------------------------------------------
module adgd_isqrt_pipe (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       en_i,
  input  wire                       valid_i,
  input  wire [adgd_pkg::ACC_W-1:0] acc_i,
  input  adgd_pkg::side_t           side_i,
  output logic                      valid_o,
  output logic [adgd_pkg::ROOT_W-1:0] root_o,
  output adgd_pkg::side_t           side_o
);
  import adgd_pkg::*;

  localparam int REM_W = 36;

  logic              v_q    [SQRT_STAGES];
  logic [ACC_W-1:0]  a_q    [SQRT_STAGES];
  logic [REM_W-1:0]  rem_q  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];
  side_t             side_q [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic              pv;
    logic [ACC_W-1:0]  pa, na;
    logic [REM_W-1:0]  prem, nrem;
    logic [ROOT_W-1:0] proot, nroot;
    side_t             pside;

    if (s == 0) begin : g_first
      assign pv    = valid_i;
      assign pa    = acc_i;
      assign prem  = '0;
      assign proot = '0;
      assign pside = side_i;
    end else begin : g_next
      assign pv    = v_q[s-1];
      assign pa    = a_q[s-1];
      assign prem  = rem_q[s-1];
      assign proot = root_q[s-1];
      assign pside = side_q[s-1];
    end

    always_comb begin
      logic [REM_W-1:0] trial;
      nrem  = prem;
      nroot = proot;
      na    = pa;
      for (int k = 0; k < 2; k++) begin
        nrem  = {nrem[REM_W-3:0], na[ACC_W-1:ACC_W-2]};
        na    = {na[ACC_W-3:0], 2'b00};
        trial = {2'b00, nroot, 2'b01};
        if (nrem >= trial) begin
          nrem  = nrem - trial;
          nroot = {nroot[ROOT_W-2:0], 1'b1};
        end else begin
          nroot = {nroot[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[s]    <= na;
        rem_q[s]  <= nrem;
        root_q[s] <= nroot;
        side_q[s] <= pside;
      end
    end
  end

  assign valid_o = v_q[SQRT_STAGES-1];
  assign root_o  = root_q[SQRT_STAGES-1];
  assign side_o  = side_q[SQRT_STAGES-1];

endmodule
`default_nettype wire

### hdl/adgd_div_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division of a 56-bit numerator by a 33-bit divisor, two bits per stage.
// ----------------------------------------------------------------------------
module adgd_div_pipe (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       en_i,
  input  wire                       valid_i,
  input  wire [adgd_pkg::QUO_W-1:0] num_i,
  input  wire [adgd_pkg::DEN_W-1:0] den_i,
  input  adgd_pkg::side_t           side_i,
  output logic                      valid_o,
  output logic [adgd_pkg::QUO_W-1:0] quo_o,
  output adgd_pkg::side_t           side_o
);
  import adgd_pkg::*;

  localparam int REM_W = DEN_W + 1;

  logic             v_q    [DIV_STAGES];
  logic [QUO_W-1:0] nq_q   [DIV_STAGES];
  logic [REM_W-1:0] rem_q  [DIV_STAGES];
  logic [DEN_W-1:0] den_q  [DIV_STAGES];
  side_t            side_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic             pv;
    logic [QUO_W-1:0] pnq, nnq;
    logic [REM_W-1:0] prem, nrem;
    logic [DEN_W-1:0] pden;
    side_t            pside;

    if (s == 0) begin : g_first
      assign pv    = valid_i;
      assign pnq   = num_i;
      assign prem  = '0;
      assign pden  = den_i;
      assign pside = side_i;
    end else begin : g_next
      assign pv    = v_q[s-1];
      assign pnq   = nq_q[s-1];
      assign prem  = rem_q[s-1];
      assign pden  = den_q[s-1];
      assign pside = side_q[s-1];
    end

    // The numerator shifts out at the top while quotient bits shift in below.
    always_comb begin
      nrem = prem;
      nnq  = pnq;
      for (int k = 0; k < 2; k++) begin
        nrem = {nrem[REM_W-2:0], nnq[QUO_W-1]};
        nnq  = {nnq[QUO_W-2:0], 1'b0};
        if (nrem >= {1'b0, pden}) begin
          nrem   = nrem - {1'b0, pden};
          nnq[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[s]   <= nnq;
        rem_q[s]  <= nrem;
        den_q[s]  <= pden;
        side_q[s] <= pside;
      end
    end
  end

  assign valid_o = v_q[DIV_STAGES-1];
  assign quo_o   = nq_q[DIV_STAGES-1];
  assign side_o  = side_q[DIV_STAGES-1];

endmodule
`default_nettype wire

### hdl/adagrad_param_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// AdaGrad parameter update
// Per-element AdaGrad weight update with a squared-gradient accumulator store.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the slave stream carries an index, a weight and its
//   gradient (Q16.16). The block adds the squared gradient into the index's
//   Q32.32 accumulator with saturation and returns, on the master stream,
//   weight - rate * gradient / (sqrt(acc) + 1 LSB), saturated.
//   Indices at or beyond NUM_WEIGHTS pass the weight through unchanged.
//   The learning rate (unsigned Q8.24) is written through cfg_we_i and
//   cfg_wdata_i, the user ensuring no item is in flight; no check is made.
// Throughput and pipeline:
//   One item per cycle while the output register is not stalled. A result
//   passes read, square and accumulate with forwarding, 16 stages of
//   square root, one multiply stage, 28 stages of division and the output
//   register. Repeated indices in consecutive cycles are forwarded.
// Reset:
//   After reset the accumulator store is cleared one entry per cycle;
//   s_axis_tready stays low during that pass.
// Stall:
//   The whole pipeline holds while the output register is full and not
//   taken; nothing is lost or repeated, and s_axis_tready drops meanwhile.
// ----------------------------------------------------------------------------
module adagrad_param_update #(
  parameter int NUM_WEIGHTS = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [31:0] cfg_wdata_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] param_index, [43:12] weight_in, [75:44] gradient, [79:76] zero
  input  wire  [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [31:0] weight_out, [43:32] out_index, [47:44] zero
  output logic [47:0] m_axis_tdata
);
  import adgd_pkg::*;

  localparam int AW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;

  // Configuration register.
  logic [DATA_W-1:0] lr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= LR_RESET;
    end else if (cfg_we_i) begin
      lr_q <= cfg_wdata_i;
    end
  end

  // Clearing pass over the accumulator store after reset.
  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      if (clr_cnt_q == AW'(NUM_WEIGHTS - 1)) begin
        clr_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Global advance: every stage moves when the output register can take data.
  logic en;
  logic accept;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !clr_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Input decode.
  logic [IDX_W-1:0]  in_idx;
  logic [DATA_W-1:0] in_w, in_g;
  side_t             in_side;
  logic [AW-1:0]     raddr;

  assign in_idx = s_axis_tdata[11:0];
  assign in_w   = s_axis_tdata[43:12];
  assign in_g   = s_axis_tdata[75:44];

  always_comb begin
    in_side.idx      = in_idx;
    in_side.weight   = in_w;
    in_side.neg      = in_g[DATA_W-1];
    in_side.mag      = in_g[DATA_W-1] ? (~in_g + 32'd1) : in_g;
    in_side.in_range = (32'(in_idx) < NUM_WEIGHTS);
    raddr            = in_side.in_range ? AW'(in_idx) : '0;
  end

  // Accumulator store.
  logic [ACC_W-1:0] mem [NUM_WEIGHTS];
  logic [ACC_W-1:0] rd_q;
  logic             wr_en;
  logic [AW-1:0]    waddr;
  logic [ACC_W-1:0] acc_d;

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (wr_en) begin
      mem[waddr] <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_q <= mem[raddr];
    end
  end

  // Stages 1 to 4: capture, square, accumulate, hold for forwarding.
  logic             v1_q, v2_q, v3_q, v4_q;
  side_t            side1_q, side2_q, side3_q, side4_q;
  logic [ACC_W-1:0] sq2_q, rd2_q, acc3_q, acc4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // The two items ahead wrote their sums after this item read the store,
  // so their results take priority over the read data, the nearer first.
  logic [ACC_W-1:0] acc_base;
  logic [ACC_W:0]   acc_sum;

  always_comb begin
    if (v3_q && side3_q.in_range && side3_q.idx == side2_q.idx) begin
      acc_base = acc3_q;
    end else if (v4_q && side4_q.in_range && side4_q.idx == side2_q.idx) begin
      acc_base = acc4_q;
    end else begin
      acc_base = rd2_q;
    end
    acc_sum = {1'b0, acc_base} + {1'b0, sq2_q};
    acc_d   = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
  end

  assign wr_en = en && v2_q && side2_q.in_range;
  assign waddr = AW'(side2_q.idx);

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q <= in_side;
      side2_q <= side1_q;
      sq2_q   <= side1_q.mag * side1_q.mag;
      rd2_q   <= rd_q;
      side3_q <= side2_q;
      acc3_q  <= acc_d;
      side4_q <= side3_q;
      acc4_q  <= acc3_q;
    end
  end

  // Square root of the updated accumulator.
  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side;

  adgd_isqrt_pipe u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .acc_i   (acc4_q),
    .side_i  (side4_q),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Numerator and divisor. The product is below 2^63; dropping its low
  // eight bits before dividing gives the same floor as shifting afterwards.
  logic                vm_q;
  logic [DEN_W-1:0]    den_q;
  logic [2*DATA_W-1:0] prod_q;
  side_t               sidem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en) begin
      vm_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q   <= {1'b0, sq_root} + 33'd1;
      prod_q  <= lr_q * sq_side.mag;
      sidem_q <= sq_side;
    end
  end

  logic             dv_v;
  logic [QUO_W-1:0] dv_quo;
  side_t            dv_side;

  adgd_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vm_q),
    .num_i   (prod_q[63:8]),
    .den_i   (den_q),
    .side_i  (sidem_q),
    .valid_o (dv_v),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // Apply the step and saturate to Q16.16; out-of-range indices keep the weight.
  logic signed [QUO_W+1:0] w_ext, d_ext, res_full;
  logic [DATA_W-1:0]       res_sat, res;

  always_comb begin
    w_ext    = {{(QUO_W - DATA_W + 2){dv_side.weight[DATA_W-1]}}, dv_side.weight};
    d_ext    = {2'b00, dv_quo};
    res_full = dv_side.neg ? (w_ext + d_ext) : (w_ext - d_ext);
    if (res_full[QUO_W+1:DATA_W-1] != {(QUO_W - DATA_W + 3){res_full[QUO_W+1]}}) begin
      res_sat = res_full[QUO_W+1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      res_sat = res_full[DATA_W-1:0];
    end
    res = dv_side.in_range ? res_sat : dv_side.weight;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= {4'b0000, dv_side.idx, res};
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s_axis_tready)
    else $error("input accepted during clearing pass");

  a_no_write_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !(v2_q && wr_en))
    else $error("accumulator update during clearing pass");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while pipeline stalled");

  a_stall_holds_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire
